@@ sv/itfla_pkg.sv @@
// Shared types and constants for the entry table allocator.
`timescale 1ns / 1ps

package itfla_pkg;

    localparam int IDX_W             = 13;
    localparam int CNT_W             = 16;
    localparam int DEF_TABLE_DEPTH   = 4096;
    localparam int DEF_DATA_WIDTH    = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_READ    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_RECLAIM = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ERROR     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic ready;
        logic accept;
        logic exec_go;
        logic clear_we;
    } t_ctl;

endpackage

@@ sv/itfla_mem.sv @@
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module itfla_mem #(
    parameter int DEPTH = itfla_pkg::DEF_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/itfla_ctrl.sv @@
// Sequencer: clearing sweep after reset, then read and execute steps per item.
`timescale 1ns / 1ps

module itfla_ctrl #(
    parameter int TABLE_DEPTH = itfla_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_free,
    output itfla_pkg::t_ctl  o_ctl,
    output logic [AW-1:0]    o_clr_addr
);

    itfla_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic              w_clr_last;

    assign w_clr_last = (r_clr_addr == AW'(TABLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= itfla_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == itfla_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itfla_pkg::S_CLEAR: if (w_clr_last) n_state = itfla_pkg::S_IDLE;
            itfla_pkg::S_IDLE:  if (i_valid)    n_state = itfla_pkg::S_EXEC;
            itfla_pkg::S_EXEC:  if (i_out_free) n_state = itfla_pkg::S_IDLE;
            default:            n_state = itfla_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            itfla_pkg::S_CLEAR: o_ctl.clear_we = 1'b1;
            itfla_pkg::S_IDLE: begin
                o_ctl.ready  = 1'b1;
                o_ctl.accept = i_valid;
            end
            itfla_pkg::S_EXEC:  o_ctl.exec_go = i_out_free;
            default:            o_ctl = '0;
        endcase
    end

    assign o_clr_addr = r_clr_addr;

endmodule

@@ sv/inode_table_free_list_allocator.sv @@
// Entry table allocator with in-table free list.
// Each accepted item reads the entry memory, then executes and registers its result.
// A new item is accepted only after the last one has executed (read then write-back on the entry memory).
// A waiting result does not block the next accept; execute holds until the output frees.
// Reset: synchronous; a clearing sweep over all TABLE_DEPTH entries (4096 by default) zeroes
// the entry memory, with o_stall high throughout.
`timescale 1ns / 1ps

module inode_table_free_list_allocator #(
    parameter int TABLE_DEPTH = itfla_pkg::DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = itfla_pkg::DEF_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_cmd,
    input  logic [itfla_pkg::IDX_W-1:0] i_entry_index,
    input  logic [itfla_pkg::IDX_W-1:0] i_record_ident,
    input  logic [DATA_WIDTH-1:0]       i_record_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [itfla_pkg::IDX_W-1:0] o_result_index,
    output logic [itfla_pkg::IDX_W-1:0] o_result_ident,
    output logic [DATA_WIDTH-1:0]       o_result_data,
    output logic                        o_corrupt_seen,
    output logic [itfla_pkg::CNT_W-1:0] o_allocated_count
);

    localparam int IW = itfla_pkg::IDX_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 2);
    localparam int XW = (PW > IW) ? PW : IW;
    localparam int VW = XW + 1;
    localparam int EW = IW + DATA_WIDTH + PW;

    itfla_pkg::t_ctl w_ctl;
    logic [AW-1:0]   w_clr_addr;
    logic            w_out_free;

    logic [2:0]            r_cmd;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_rid;
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [PW-1:0]                 r_free_head, n_free_head;
    logic [PW-1:0]                 r_high_water, n_high_water;
    logic [itfla_pkg::CNT_W-1:0]   r_create_total, n_create_total;

    logic                  r_out_valid;
    logic [1:0]            r_status, n_status;
    logic [IW-1:0]         r_res_index, n_res_index;
    logic [IW-1:0]         r_res_ident, n_res_ident;
    logic [DATA_WIDTH-1:0] r_res_data, n_res_data;
    logic                  r_corrupt, n_corrupt;

    logic [VW-1:0]         w_raddr_full;
    logic [EW-1:0]         w_rd;
    logic [IW-1:0]         w_rd_ident;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic [PW-1:0]         w_rd_next;

    logic [VW-1:0] w_head, w_hw, w_idx, w_alloc, w_new_head, w_new_hw;
    logic          w_ex_we;
    logic [VW-1:0] w_ex_addr_full;
    logic [EW-1:0] w_ex_wdata;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [EW-1:0] w_mem_wdata;

    function automatic logic index_ok(input logic [VW-1:0] n);
        return (n != '0) && (n <= VW'(TABLE_DEPTH));
    endfunction

    assign w_out_free = !r_out_valid || !i_stall;

    itfla_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_out_free(w_out_free),
        .o_ctl     (w_ctl),
        .o_clr_addr(w_clr_addr)
    );

    assign o_stall = !w_ctl.ready;

    assign w_raddr_full = ((itfla_pkg::t_cmd'(i_cmd) == itfla_pkg::CMD_CREATE)
                           ? VW'(r_free_head) : VW'(i_entry_index)) - VW'(1);

    itfla_mem #(
        .DEPTH(TABLE_DEPTH),
        .AW   (AW),
        .WIDTH(EW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_mem_waddr),
        .i_wdata(w_mem_wdata),
        .i_re   (w_ctl.accept),
        .i_raddr(w_raddr_full[AW-1:0]),
        .o_rdata(w_rd)
    );

    assign w_rd_ident = w_rd[EW-1 -: IW];
    assign w_rd_data  = w_rd[PW +: DATA_WIDTH];
    assign w_rd_next  = w_rd[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_idx   <= i_entry_index;
            r_rid   <= i_record_ident;
            r_rdata <= i_record_data;
        end
    end

    assign w_head = VW'(r_free_head);
    assign w_hw   = VW'(r_high_water);
    assign w_idx  = VW'(r_idx);

    always_comb begin
        w_alloc        = w_head;
        w_new_head     = w_head;
        w_new_hw       = w_hw;
        n_free_head    = r_free_head;
        n_high_water   = r_high_water;
        n_create_total = r_create_total;
        n_status       = itfla_pkg::ST_OK;
        n_res_index    = r_idx;
        n_res_ident    = '0;
        n_res_data     = '0;
        n_corrupt      = 1'b0;
        w_ex_we        = 1'b0;
        w_ex_addr_full = w_idx - VW'(1);
        w_ex_wdata     = '0;
        unique case (itfla_pkg::t_cmd'(r_cmd))
            itfla_pkg::CMD_CREATE: begin
                if (w_head == w_hw + VW'(1)) begin
                    w_alloc    = w_head;
                    w_new_hw   = w_hw + VW'(1);
                    w_new_head = w_head + VW'(1);
                end else if (index_ok(w_head) && w_rd_ident == '0) begin
                    w_alloc    = w_head;
                    w_new_head = VW'(w_rd_next);
                end else begin
                    n_corrupt  = 1'b1;
                    w_new_hw   = w_hw + VW'(1);
                    w_alloc    = w_hw + VW'(1);
                    w_new_head = w_hw + VW'(2);
                end
                n_res_index = w_alloc[IW-1:0];
                if (!index_ok(w_alloc)) begin
                    n_status = itfla_pkg::ST_ERROR;
                end else begin
                    n_high_water   = w_new_hw[PW-1:0];
                    n_free_head    = w_new_head[PW-1:0];
                    w_ex_we        = 1'b1;
                    w_ex_addr_full = w_alloc - VW'(1);
                    w_ex_wdata     = {w_alloc[IW-1:0], r_rdata, {PW{1'b0}}};
                    if (r_create_total != itfla_pkg::CNT_MAX) begin
                        n_create_total = r_create_total + itfla_pkg::CNT_W'(1);
                    end
                end
            end
            itfla_pkg::CMD_READ: begin
                if (!index_ok(w_idx)) begin
                    n_status = itfla_pkg::ST_ERROR;
                end else begin
                    n_res_ident = w_rd_ident;
                    n_res_data  = w_rd_data;
                    if (w_rd_ident == '0) n_status = itfla_pkg::ST_NOT_FOUND;
                end
            end
            itfla_pkg::CMD_WRITE: begin
                if (!index_ok(w_idx)) begin
                    n_status = itfla_pkg::ST_ERROR;
                end else begin
                    w_ex_we    = 1'b1;
                    w_ex_wdata = {r_rid, r_rdata, {PW{1'b0}}};
                end
            end
            itfla_pkg::CMD_DELETE: begin
                if (!index_ok(w_idx)) begin
                    n_status = itfla_pkg::ST_ERROR;
                end else begin
                    w_ex_we = 1'b1;
                end
            end
            itfla_pkg::CMD_RECLAIM: begin
                if (!index_ok(w_idx)) begin
                    n_status = itfla_pkg::ST_ERROR;
                end else begin
                    w_ex_we     = 1'b1;
                    w_ex_wdata  = {{IW{1'b0}}, {DATA_WIDTH{1'b0}}, r_free_head};
                    n_free_head = w_idx[PW-1:0];
                end
            end
            default: n_status = itfla_pkg::ST_OK;
        endcase
    end

    always_comb begin
        if (w_ctl.clear_we) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_ctl.exec_go && w_ex_we;
            w_mem_waddr = w_ex_addr_full[AW-1:0];
            w_mem_wdata = w_ex_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head    <= PW'(1);
            r_high_water   <= '0;
            r_create_total <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_ctl.exec_go) begin
                r_free_head    <= n_free_head;
                r_high_water   <= n_high_water;
                r_create_total <= n_create_total;
                r_out_valid    <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.exec_go) begin
            r_status    <= n_status;
            r_res_index <= n_res_index;
            r_res_ident <= n_res_ident;
            r_res_data  <= n_res_data;
            r_corrupt   <= n_corrupt;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_result_index    = r_res_index;
    assign o_result_ident    = r_res_ident;
    assign o_result_data     = r_res_data;
    assign o_corrupt_seen    = r_corrupt;
    assign o_allocated_count = r_create_total;

endmodule

@@ tb/sv/table_alloc_checker.sv @@
// Checker that predicts and compares the results of the entry table allocator.
`timescale 1ns / 1ps

module table_alloc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [2:0]                  i_cmd,
    input  logic [itfla_pkg::IDX_W-1:0] i_entry_index,
    input  logic [itfla_pkg::IDX_W-1:0] i_record_ident,
    input  logic [31:0]                 i_record_data,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_stall,
    input  logic [1:0]                  i_status,
    input  logic [itfla_pkg::IDX_W-1:0] i_result_index,
    input  logic [itfla_pkg::IDX_W-1:0] i_result_ident,
    input  logic [31:0]                 i_result_data,
    input  logic                        i_corrupt_seen,
    input  logic [itfla_pkg::CNT_W-1:0] i_allocated_count,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int DEPTH = itfla_pkg::DEF_TABLE_DEPTH;
    localparam int IW    = itfla_pkg::IDX_W;
    localparam int CW    = itfla_pkg::CNT_W;

    typedef struct packed {
        logic [1:0]    status;
        logic [IW-1:0] index;
        logic [IW-1:0] ident;
        logic [31:0]   data;
        logic          corrupt;
        logic [CW-1:0] count;
    } t_table_result;

    logic [IW-1:0] ident_mem [1:DEPTH];
    logic [31:0]   data_mem  [1:DEPTH];
    logic [IW-1:0] link_mem  [1:DEPTH];
    int            free_head;
    int            high_water;
    logic [CW-1:0] create_total;
    t_table_result expected_results [$];
    int            fail_count = 0;

    function automatic bit in_table(input int n);
        return n >= 1 && n <= DEPTH;
    endfunction

    function automatic t_table_result run_command(input logic [2:0] cmd,
                                                  input logic [IW-1:0] idx,
                                                  input logic [IW-1:0] rid,
                                                  input logic [31:0] rdata);
        t_table_result r;
        int            head;
        int            alloc;
        int            new_head;
        int            new_hw;
        int            n;
        r.status  = itfla_pkg::ST_OK;
        r.index   = idx;
        r.ident   = '0;
        r.data    = '0;
        r.corrupt = 1'b0;
        n         = idx;
        case (cmd) inside
            itfla_pkg::CMD_CREATE: begin
                head   = free_head;
                new_hw = high_water;
                if (head == high_water + 1) begin
                    alloc    = head;
                    new_hw   = high_water + 1;
                    new_head = head + 1;
                end else if (in_table(head) && ident_mem[head] == '0) begin
                    alloc    = head;
                    new_head = link_mem[head];
                end else begin
                    r.corrupt = 1'b1;
                    new_hw    = high_water + 1;
                    alloc     = new_hw;
                    new_head  = new_hw + 1;
                end
                r.index = alloc[IW-1:0];
                if (!in_table(alloc)) begin
                    r.status = itfla_pkg::ST_ERROR;
                end else begin
                    high_water       = new_hw;
                    free_head        = new_head;
                    ident_mem[alloc] = alloc[IW-1:0];
                    data_mem[alloc]  = rdata;
                    link_mem[alloc]  = '0;
                    if (create_total != itfla_pkg::CNT_MAX)
                        create_total = create_total + 1'b1;
                end
            end
            itfla_pkg::CMD_READ, itfla_pkg::CMD_WRITE, itfla_pkg::CMD_DELETE,
            itfla_pkg::CMD_RECLAIM: begin
                if (!in_table(n)) begin
                    r.status = itfla_pkg::ST_ERROR;
                end else if (cmd == itfla_pkg::CMD_READ) begin
                    r.ident = ident_mem[n];
                    r.data  = data_mem[n];
                    if (ident_mem[n] == '0) r.status = itfla_pkg::ST_NOT_FOUND;
                end else if (cmd == itfla_pkg::CMD_WRITE) begin
                    ident_mem[n] = rid;
                    data_mem[n]  = rdata;
                    link_mem[n]  = '0;
                end else if (cmd == itfla_pkg::CMD_DELETE) begin
                    ident_mem[n] = '0;
                    data_mem[n]  = '0;
                    link_mem[n]  = '0;
                end else begin
                    ident_mem[n] = '0;
                    data_mem[n]  = '0;
                    link_mem[n]  = free_head[IW-1:0];
                    free_head    = n;
                end
            end
            default: ;
        endcase
        r.count = create_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (!i_rst_n) begin
            for (int n = 1; n <= DEPTH; n++) begin
                ident_mem[n] = '0;
                data_mem[n]  = '0;
                link_mem[n]  = '0;
            end
            free_head    = 1;
            high_water   = 0;
            create_total = '0;
            expected_results.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result item: st=%0d idx=%0d id=%0d data=%h",
                                 $time, i_status, i_result_index, i_result_ident,
                                 i_result_data);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_status !== exp_r.status || i_result_index !== exp_r.index ||
                        i_result_ident !== exp_r.ident || i_result_data !== exp_r.data ||
                        i_corrupt_seen !== exp_r.corrupt ||
                        i_allocated_count !== exp_r.count) begin
                        if (fail_count < 10) begin
                            $display({"%0t: mismatch exp st=%0d idx=%0d id=%0d",
                                      " data=%h cor=%0d cnt=%0d"},
                                     $time, exp_r.status, exp_r.index, exp_r.ident,
                                     exp_r.data, exp_r.corrupt, exp_r.count);
                            $display({"%0t:          got st=%0d idx=%0d id=%0d",
                                      " data=%h cor=%0d cnt=%0d"},
                                     $time, i_status, i_result_index, i_result_ident,
                                     i_result_data, i_corrupt_seen, i_allocated_count);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(run_command(i_cmd, i_entry_index,
                                                       i_record_ident, i_record_data));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ tb/sv/inode_table_free_list_allocator_tb.sv @@
// Top of the entry table allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module inode_table_free_list_allocator_tb;

    localparam int IW           = itfla_pkg::IDX_W;
    localparam int CW           = itfla_pkg::CNT_W;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int DEPTH        = itfla_pkg::DEF_TABLE_DEPTH;
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH);
    localparam logic [IW-1:0] IDX_PAST = IW'(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1350;
    localparam int FILL_ITEMS   = 64;
    localparam int FINAL_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [2:0]    i_cmd;
    logic [IW-1:0] i_entry_index;
    logic [IW-1:0] i_record_ident;
    logic [31:0]   i_record_data;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [1:0]    o_status;
    logic [IW-1:0] o_result_index;
    logic [IW-1:0] o_result_ident;
    logic [31:0]   o_result_data;
    logic          o_corrupt_seen;
    logic [CW-1:0] o_allocated_count;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet          = 1'b0;
    bit sender_calm    = 1'b0;
    bit receiver_calm  = 1'b0;

    inode_table_free_list_allocator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_record_ident    (i_record_ident),
        .i_record_data     (i_record_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_result_index    (o_result_index),
        .o_result_ident    (o_result_ident),
        .o_result_data     (o_result_data),
        .o_corrupt_seen    (o_corrupt_seen),
        .o_allocated_count (o_allocated_count)
    );

    table_alloc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_cmd             (i_cmd),
        .i_entry_index     (i_entry_index),
        .i_record_ident    (i_record_ident),
        .i_record_data     (i_record_data),
        .i_rsp_valid       (o_valid),
        .i_rsp_stall       (i_stall),
        .i_status          (o_status),
        .i_result_index    (o_result_index),
        .i_result_ident    (o_result_ident),
        .i_result_data     (o_result_data),
        .i_corrupt_seen    (o_corrupt_seen),
        .i_allocated_count (o_allocated_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result-side stall bursts, with calm stretches
    always @(negedge i_clk) begin
        if ($urandom_range(299) == 0) receiver_calm <= !receiver_calm;
        if (quiet || receiver_calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(9, 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send(input logic [2:0] cmd, input logic [IW-1:0] idx,
                        input logic [IW-1:0] ident, input logic [31:0] payload);
        if (!quiet && !sender_calm && $urandom_range(3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_cmd          = cmd;
        i_entry_index  = idx;
        i_record_ident = ident;
        i_record_data  = payload;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if ($urandom_range(39) == 0) sender_calm = !sender_calm;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    function automatic logic [IW-1:0] rand_entry();
        int r;
        r = $urandom_range(99);
        if (r < 65) return IW'($urandom_range(48, 1));
        if (r < 80) return IW'($urandom_range(DEPTH, 1));
        if (r < 90) return IW'($urandom_range(8191, 0));
        case ($urandom_range(3))
            0:       return '0;
            1:       return IDX_LAST;
            2:       return IDX_PAST;
            default: return '1;
        endcase
    endfunction

    function automatic logic [IW-1:0] rand_ident();
        if ($urandom_range(9) == 0) return '0;
        return IW'($urandom_range(8191, 0));
    endfunction

    function automatic logic [31:0] rand_payload();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic send_random_item();
        int            pick;
        logic [IW-1:0] idx;
        pick = $urandom_range(99);
        idx  = rand_entry();
        if (pick < 26) begin
            send(itfla_pkg::CMD_CREATE, idx, rand_ident(), rand_payload());
        end else if (pick < 50) begin
            send(itfla_pkg::CMD_READ, idx, rand_ident(), rand_payload());
        end else if (pick < 66) begin
            send(itfla_pkg::CMD_WRITE, idx, rand_ident(), rand_payload());
        end else if (pick < 74) begin
            send(itfla_pkg::CMD_DELETE, idx, rand_ident(), rand_payload());
        end else if (pick < 86) begin
            send(itfla_pkg::CMD_RECLAIM, idx, rand_ident(), rand_payload());
        end else if (pick < 94) begin
            // recycle an entry and read it back
            send(itfla_pkg::CMD_RECLAIM, idx, rand_ident(), rand_payload());
            send(itfla_pkg::CMD_CREATE, rand_entry(), rand_ident(), rand_payload());
            send(itfla_pkg::CMD_READ, idx, rand_ident(), rand_payload());
        end else begin
            send(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), idx, rand_ident(),
                 rand_payload());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = itfla_pkg::CMD_CREATE;
        i_entry_index  = '0;
        i_record_ident = '0;
        i_record_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(itfla_pkg::CMD_READ,    13'd1,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_CREATE,  13'd0,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_CREATE,  13'd8191, 13'd8191, 32'hFFFF_FFFF);
        send(itfla_pkg::CMD_READ,    13'd2,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_READ,    13'd0,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_READ,    13'd8191, 13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_WRITE,   13'd0,    13'd5,    32'h1234_5678);
        send(itfla_pkg::CMD_DELETE,  IDX_PAST, 13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_RECLAIM, 13'd0,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_WRITE,   IDX_LAST, 13'd8191, 32'hA5A5_A5A5);
        send(itfla_pkg::CMD_READ,    IDX_LAST, 13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_DELETE,  13'd2,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_READ,    13'd2,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_RECLAIM, 13'd2,    13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_CREATE,  13'd0,    13'd0,    32'h0BAD_F00D);
        // live entry at the free head
        send(itfla_pkg::CMD_RECLAIM, IDX_LAST, 13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_WRITE,   IDX_LAST, IDX_LAST, 32'h5A5A_5A5A);
        send(itfla_pkg::CMD_CREATE,  13'd0,    13'd0,    32'hDEAD_BEEF);
        // free head popped to zero
        send(itfla_pkg::CMD_RECLAIM, 13'd10,   13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_WRITE,   13'd10,   13'd0,    32'h0000_0000);
        send(itfla_pkg::CMD_CREATE,  13'd0,    13'd0,    32'hCAFE_0001);
        send(itfla_pkg::CMD_CREATE,  13'd0,    13'd0,    32'hCAFE_0002);
        send(CMD_SPARE_LO,           13'd1,    13'd1,    32'h0000_0001);
        send(CMD_SPARE_HI,           13'd1,    13'd1,    32'h0000_0001);
        send(itfla_pkg::CMD_READ,    13'd10,   13'd0,    32'h0000_0000);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_item();
            if (n == RANDOM_ITEMS / 2) drain();
        end

        // grow the table with a burst of creates
        for (int n = 0; n < FILL_ITEMS; n++) begin
            if (n % 16 == 15)
                send(itfla_pkg::CMD_READ, rand_entry(), rand_ident(), rand_payload());
            else
                send(itfla_pkg::CMD_CREATE, rand_entry(), rand_ident(), rand_payload());
        end

        quiet = 1'b1;
        for (int n = 0; n < FINAL_ITEMS; n++) send_random_item();

        i_valid = 1'b0;
        wait (pending == 0);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/itfla_pkg.sv
sv/itfla_mem.sv
sv/itfla_ctrl.sv
sv/inode_table_free_list_allocator.sv
tb/sv/table_alloc_checker.sv
tb/sv/inode_table_free_list_allocator_tb.sv
